@@ hdl/vefc_pkg.sv @@
// Package for the voxel exposed-face culler: widths, codes, state type.
// No dependencies; every other file of the block imports it.
package vefc_pkg;

    localparam int MAX_AXIS_DEF = 64;

    localparam int COORD_W = 6;
    localparam int COLOR_W = 8;
    localparam int GRID_W  = 7;
    localparam int DIR_W   = 3;
    localparam int CNT_W   = 21;
    localparam int CFG_W   = 2;
    localparam int NCW     = 8;   // neighbor coordinate, two's complement, -1..64
    localparam int LW      = 9;   // effective axis limit, up to MAX_AXIS

    localparam logic [GRID_W-1:0] GRID_RESET  = 7'd64;
    localparam logic [CNT_W-1:0]  COUNTER_MAX = 21'h1FFFFF;
    localparam int                NUM_DIRS    = 6;

    // Item function codes
    localparam logic FUNC_MARK = 1'b0;
    localparam logic FUNC_CULL = 1'b1;

    typedef enum logic [DIR_W-1:0] {
        DIR_NEG_X = 3'd0,
        DIR_POS_X = 3'd1,
        DIR_NEG_Y = 3'd2,
        DIR_POS_Y = 3'd3,
        DIR_NEG_Z = 3'd4,
        DIR_POS_Z = 3'd5,
        DIR_SELF  = 3'd6
    } t_dir;

    typedef enum logic [CFG_W-1:0] {
        REG_GRID_X = 2'd0,
        REG_GRID_Y = 2'd1,
        REG_GRID_Z = 2'd2
    } t_cfg_idx;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MARK_RD,
        ST_MARK_WR,
        ST_READ,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic [GRID_W-1:0] x;
        logic [GRID_W-1:0] y;
        logic [GRID_W-1:0] z;
    } t_grid;

endpackage

@@ hdl/vefc_if.sv @@
// Channel interfaces of the voxel exposed-face culler: voxel input,
// face record output, configuration write. Depends on vefc_pkg.
interface vefc_in_if import vefc_pkg::*;;
    logic               valid;
    logic               ready;
    logic               func;
    logic [COORD_W-1:0] voxel_x;
    logic [COORD_W-1:0] voxel_y;
    logic [COORD_W-1:0] voxel_z;
    logic [COLOR_W-1:0] color_index;

    modport source(output valid, func, voxel_x, voxel_y, voxel_z, color_index,
                   input ready);
    modport sink(input valid, func, voxel_x, voxel_y, voxel_z, color_index,
                 output ready);
endinterface

interface vefc_face_if import vefc_pkg::*;;
    logic               valid;
    logic               ready;
    logic [DIR_W-1:0]   face_dir;
    logic [COORD_W-1:0] face_x;
    logic [COORD_W-1:0] face_y;
    logic [COORD_W-1:0] face_z;
    logic [COLOR_W-1:0] face_color;
    logic               face_valid;
    logic               last_of_voxel;
    logic [CNT_W-1:0]   exposed_total;

    modport source(output valid, face_dir, face_x, face_y, face_z, face_color,
                   face_valid, last_of_voxel, exposed_total, input ready);
    modport sink(input valid, face_dir, face_x, face_y, face_z, face_color,
                 face_valid, last_of_voxel, exposed_total, output ready);
endinterface

interface vefc_cfg_if import vefc_pkg::*;;
    logic              valid;
    logic              ready;
    logic [CFG_W-1:0]  index;
    logic [GRID_W-1:0] data;

    modport source(output valid, index, data, input ready);
    modport sink(input valid, index, data, output ready);
endinterface

@@ hdl/vefc_nbr_unit.sv @@
// Shared neighbor address unit: offsets a voxel by one step, checks the grid
// and forms the bitmap row address and bit index. Depends on vefc_pkg.
module vefc_nbr_unit import vefc_pkg::*; #(
    parameter int MAX_AXIS = MAX_AXIS_DEF,
    parameter int BW       = $clog2(MAX_AXIS),
    parameter int RAW      = $clog2(MAX_AXIS * MAX_AXIS)
) (
    input  t_dir               i_dir,
    input  logic [COORD_W-1:0] i_x,
    input  logic [COORD_W-1:0] i_y,
    input  logic [COORD_W-1:0] i_z,
    input  t_grid              i_grid,
    output logic               o_in_grid,
    output logic [RAW-1:0]     o_row,
    output logic [BW-1:0]      o_bit
);

    logic [NCW-1:0] w_dx, w_dy, w_dz;
    logic [NCW-1:0] w_nx, w_ny, w_nz;
    logic [LW-1:0]  w_lim_x, w_lim_y, w_lim_z;

    always_comb begin
        w_dx = '0;
        w_dy = '0;
        w_dz = '0;
        case (i_dir)
            DIR_NEG_X: w_dx = '1;
            DIR_POS_X: w_dx = NCW'(1);
            DIR_NEG_Y: w_dy = '1;
            DIR_POS_Y: w_dy = NCW'(1);
            DIR_NEG_Z: w_dz = '1;
            DIR_POS_Z: w_dz = NCW'(1);
            default: ;
        endcase
    end

    assign w_nx = NCW'(i_x) + w_dx;
    assign w_ny = NCW'(i_y) + w_dy;
    assign w_nz = NCW'(i_z) + w_dz;

    // Clamp each axis to the bitmap stride
    assign w_lim_x = (LW'(i_grid.x) > LW'(MAX_AXIS)) ? LW'(MAX_AXIS) : LW'(i_grid.x);
    assign w_lim_y = (LW'(i_grid.y) > LW'(MAX_AXIS)) ? LW'(MAX_AXIS) : LW'(i_grid.y);
    assign w_lim_z = (LW'(i_grid.z) > LW'(MAX_AXIS)) ? LW'(MAX_AXIS) : LW'(i_grid.z);

    assign o_in_grid = !w_nx[NCW-1] && !w_ny[NCW-1] && !w_nz[NCW-1] &&
                       (LW'(w_nx) < w_lim_x) && (LW'(w_ny) < w_lim_y) &&
                       (LW'(w_nz) < w_lim_z);

    assign o_row = RAW'(RAW'(w_nz[BW-1:0]) * RAW'(MAX_AXIS)) + RAW'(w_ny[BW-1:0]);
    assign o_bit = w_nx[BW-1:0];

endmodule

@@ hdl/vefc_occ_mem.sv @@
// Occupancy bitmap storage: one row of cells along x per word, one write
// port and one registered read port. Depends on vefc_pkg.
module vefc_occ_mem import vefc_pkg::*; #(
    parameter int MAX_AXIS = MAX_AXIS_DEF,
    parameter int RAW      = $clog2(MAX_AXIS * MAX_AXIS)
) (
    input  logic                i_clk,
    input  logic                i_wr_en,
    input  logic [RAW-1:0]      i_wr_addr,
    input  logic [MAX_AXIS-1:0] i_wr_data,
    input  logic [RAW-1:0]      i_rd_addr,
    output logic [MAX_AXIS-1:0] o_rd_data
);

    localparam int ROWS = MAX_AXIS * MAX_AXIS;

    logic [MAX_AXIS-1:0] r_mem [ROWS];
    logic [MAX_AXIS-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ hdl/voxel_exposed_face_culler.sv @@
// Voxel exposed-face culler. Mark items (func 0) set the voxel's bit in an
// occupancy bitmap; cull items (func 1) test the six axis neighbors in the
// order -x, +x, -y, +y, -z, +z and send one face record per empty neighbor,
// the final one flagged last_of_voxel, with a saturating running count of
// exposed faces. A cull with no empty neighbor sends one record with
// face_valid low. Cells outside the configured grid read as empty; marks
// outside it are dropped. The bitmap is one memory of MAX_AXIS*MAX_AXIS rows
// of MAX_AXIS bits with a single read port, and one neighbor address unit
// serves every lookup. After reset a clearing pass zeroes all
// MAX_AXIS*MAX_AXIS rows (4096 at the default), one per cycle, with input
// ready low. A mark steps through accept, row read and row write back; one
// outside the grid is dropped after the row read. A cull steps through the
// accept and the six serialized row reads, then scans one neighbor per
// cycle up to the last exposed one (1 to 6), stalling on an exposed one
// while the face sink holds ready low on a pending record. Input ready is
// high only between items; the output register lets the last record wait
// while the next item is taken. Configuration writes are taken every cycle.
module voxel_exposed_face_culler import vefc_pkg::*; #(
    parameter int MAX_AXIS = MAX_AXIS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    vefc_in_if.sink      i_item,
    vefc_face_if.source  o_face,
    vefc_cfg_if.sink     i_cfg
);

    localparam int BW   = $clog2(MAX_AXIS);
    localparam int RAW  = $clog2(MAX_AXIS * MAX_AXIS);
    localparam int ROWS = MAX_AXIS * MAX_AXIS;

    t_state r_state, n_state;

    // Configuration
    t_grid r_grid;

    // Latched item
    logic [COORD_W-1:0] r_x, r_y, r_z;
    logic [COLOR_W-1:0] r_color;

    // Sequencer
    logic [RAW-1:0]      r_clr;
    logic [DIR_W-1:0]    r_dir, n_dir;
    logic                r_pend;
    logic [DIR_W-1:0]    r_pend_dir;
    logic [BW-1:0]       r_pend_bit;
    logic                r_pend_in;
    logic [NUM_DIRS-1:0] r_occ;
    logic [RAW-1:0]      r_row;
    logic [BW-1:0]       r_bit;
    logic [CNT_W-1:0]    r_cnt, n_cnt;

    // Output register
    logic               r_out_valid;
    logic [DIR_W-1:0]   r_face_dir;
    logic               r_face_valid;
    logic               r_last;
    logic [CNT_W-1:0]   r_total;
    logic [COORD_W-1:0] r_face_x, r_face_y, r_face_z;
    logic [COLOR_W-1:0] r_face_color;

    // Shared unit and memory
    t_dir                w_unit_dir;
    logic                w_in_grid;
    logic [RAW-1:0]      w_row;
    logic [BW-1:0]       w_bit;
    logic                w_wr_en;
    logic [RAW-1:0]      w_wr_addr;
    logic [MAX_AXIS-1:0] w_wr_data;
    logic [MAX_AXIS-1:0] w_rd_data;

    // Emit control
    logic                w_in_xfer;
    logic                w_slot;
    logic [NUM_DIRS-1:0] w_exp;
    logic                w_hidden;
    logic                w_cur_exp;
    logic                w_more;
    logic                w_load;
    logic                w_load_valid;
    logic                w_load_last;

    assign w_in_xfer = i_item.valid && i_item.ready;
    assign w_slot    = !r_out_valid || o_face.ready;

    assign w_unit_dir = (r_state == ST_MARK_RD) ? DIR_SELF : t_dir'(r_dir);

    vefc_nbr_unit #(
        .MAX_AXIS (MAX_AXIS),
        .BW       (BW),
        .RAW      (RAW)
    ) u_nbr (
        .i_dir     (w_unit_dir),
        .i_x       (r_x),
        .i_y       (r_y),
        .i_z       (r_z),
        .i_grid    (r_grid),
        .o_in_grid (w_in_grid),
        .o_row     (w_row),
        .o_bit     (w_bit)
    );

    vefc_occ_mem #(
        .MAX_AXIS (MAX_AXIS),
        .RAW      (RAW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_addr (w_row),
        .o_rd_data (w_rd_data)
    );

    // Clear rows during the clearing pass, write back the marked row after
    // its read
    always_comb begin
        w_wr_en   = 1'b0;
        w_wr_addr = r_clr;
        w_wr_data = '0;
        case (r_state)
            ST_CLEAR: begin
                w_wr_en = 1'b1;
            end
            ST_MARK_WR: begin
                w_wr_en   = 1'b1;
                w_wr_addr = r_row;
                w_wr_data = w_rd_data | (MAX_AXIS'(1) << r_bit);
            end
            default: ;
        endcase
    end

    // Exposed-face scan
    assign w_exp     = ~r_occ;
    assign w_hidden  = (r_occ == '1);
    assign w_cur_exp = w_exp[r_dir];

    always_comb begin
        w_more = 1'b0;
        for (int i = 0; i < NUM_DIRS; i++) begin
            if (DIR_W'(i) > r_dir && w_exp[i]) begin
                w_more = 1'b1;
            end
        end
    end

    assign n_cnt = (r_cnt == COUNTER_MAX) ? r_cnt : r_cnt + CNT_W'(1);

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: begin
                if (r_clr == RAW'(ROWS - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (w_in_xfer) begin
                    n_state = (i_item.func == FUNC_CULL) ? ST_READ : ST_MARK_RD;
                end
            end
            ST_MARK_RD: begin
                n_state = w_in_grid ? ST_MARK_WR : ST_IDLE;
            end
            ST_MARK_WR: begin
                n_state = ST_IDLE;
            end
            ST_READ: begin
                if (r_dir == DIR_SELF) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (w_slot && (w_hidden || (w_cur_exp && !w_more))) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Sequencer outputs
    always_comb begin
        n_dir        = r_dir;
        w_load       = 1'b0;
        w_load_valid = 1'b0;
        w_load_last  = 1'b0;
        case (r_state)
            ST_IDLE: begin
                n_dir = DIR_NEG_X;
            end
            ST_READ: begin
                n_dir = (r_dir == DIR_SELF) ? DIR_W'(DIR_NEG_X) : r_dir + DIR_W'(1);
            end
            ST_EMIT: begin
                if (w_hidden) begin
                    w_load      = w_slot;
                    w_load_last = 1'b1;
                end else if (w_cur_exp) begin
                    w_load       = w_slot;
                    w_load_valid = 1'b1;
                    w_load_last  = !w_more;
                    if (w_slot) begin
                        n_dir = r_dir + DIR_W'(1);
                    end
                end else begin
                    n_dir = r_dir + DIR_W'(1);
                end
            end
            default: ;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr       <= '0;
            r_dir       <= DIR_NEG_X;
            r_pend      <= 1'b0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
            r_grid.x    <= GRID_RESET;
            r_grid.y    <= GRID_RESET;
            r_grid.z    <= GRID_RESET;
        end else begin
            r_state <= n_state;
            r_dir   <= n_dir;
            if (r_state == ST_CLEAR) begin
                r_clr <= r_clr + RAW'(1);
            end
            // A read is in flight while directions are being issued
            r_pend <= (r_state == ST_READ) && (r_dir != DIR_SELF);
            if (w_load && w_load_valid) begin
                r_cnt <= n_cnt;
            end
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (o_face.ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg.valid) begin
                case (i_cfg.index)
                    REG_GRID_X: r_grid.x <= i_cfg.data;
                    REG_GRID_Y: r_grid.y <= i_cfg.data;
                    REG_GRID_Z: r_grid.z <= i_cfg.data;
                    default: ;
                endcase
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_x     <= i_item.voxel_x;
            r_y     <= i_item.voxel_y;
            r_z     <= i_item.voxel_z;
            r_color <= i_item.color_index;
        end
        if (r_state == ST_MARK_RD) begin
            r_row <= w_row;
            r_bit <= w_bit;
        end
        if (r_state == ST_READ) begin
            r_pend_dir <= r_dir;
            r_pend_bit <= w_bit;
            r_pend_in  <= w_in_grid;
        end
        // Collect the neighbor bit in the cycle after its row read is issued
        if (r_pend) begin
            r_occ[r_pend_dir] <= r_pend_in && w_rd_data[r_pend_bit];
        end
        if (w_load) begin
            r_face_dir   <= w_hidden ? DIR_W'(DIR_NEG_X) : r_dir;
            r_face_valid <= w_load_valid;
            r_last       <= w_load_last;
            r_total      <= w_load_valid ? n_cnt : r_cnt;
            r_face_x     <= r_x;
            r_face_y     <= r_y;
            r_face_z     <= r_z;
            r_face_color <= r_color;
        end
    end

    assign i_item.ready = (r_state == ST_IDLE);
    assign i_cfg.ready  = 1'b1;

    assign o_face.valid         = r_out_valid;
    assign o_face.face_dir      = r_face_dir;
    assign o_face.face_x        = r_face_x;
    assign o_face.face_y        = r_face_y;
    assign o_face.face_z        = r_face_z;
    assign o_face.face_color    = r_face_color;
    assign o_face.face_valid    = r_face_valid;
    assign o_face.last_of_voxel = r_last;
    assign o_face.exposed_total = r_total;

endmodule
